>>> hw/rtl/sbsm_pkg.sv
package sbsm_pkg;

	// Request type codes
	localparam logic [1:0] REQ_CPU_RD = 2'd0;
	localparam logic [1:0] REQ_CPU_WR = 2'd1;
	localparam logic [1:0] REQ_VID_RD = 2'd2;
	localparam logic [1:0] REQ_VID_WR = 2'd3;

	// Serial write targets, address bits 14:13
	localparam logic [1:0] TGT_CONTROL = 2'd0;
	localparam logic [1:0] TGT_PRG     = 2'd3;

	// Program modes, control bits 3:2
	localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
	localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

	localparam int unsigned SHIFT_W = 5;
	localparam int unsigned BANK_W  = 4;
	localparam int unsigned WIDE_W  = 3;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned MAP_W   = 18;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 5'b10000;
	localparam logic [4:0]         CONTROL_RESET = 5'h1C;
	localparam logic [BANK_W-1:0]  HIGH_RESET    = 4'd15;
	localparam logic [COUNT_W-1:0] COUNT_RESET   = 5'd16;
	localparam logic [2:0]         LAST_BIT_IDX  = 3'd4;

	typedef struct packed {
		logic [4:0]        control;
		logic [BANK_W-1:0] low_bank;
		logic [BANK_W-1:0] high_bank;
		logic [WIDE_W-1:0] wide_bank;
	} bank_state_t;

endpackage

>>> hw/rtl/sbsm_regs.sv
module sbsm_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [15:0]                   wr_addr,
	input  logic [7:0]                    wr_data,
	input  logic                          cfg_we,
	input  logic [sbsm_pkg::COUNT_W-1:0]  cfg_count,
	output sbsm_pkg::bank_state_t         banks
);
	import sbsm_pkg::*;

	logic [SHIFT_W-1:0] shift_bits_q;
	logic [2:0]         write_count_q;
	logic [4:0]         control_q;
	logic [BANK_W-1:0]  low_bank_q;
	logic [BANK_W-1:0]  high_bank_q;
	logic [WIDE_W-1:0]  wide_bank_q;
	logic [COUNT_W-1:0] bank_count_q;

	logic [SHIFT_W-1:0] shift_next;
	logic [COUNT_W-1:0] count_m1;
	logic               last_bit;

	assign shift_next = {wr_data[0], shift_bits_q[SHIFT_W-1:1]};
	assign last_bit   = (write_count_q == LAST_BIT_IDX);
	assign count_m1   = bank_count_q - COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			bank_count_q <= cfg_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_bits_q  <= SHIFT_RESET;
			write_count_q <= '0;
			control_q     <= CONTROL_RESET;
			low_bank_q    <= '0;
			high_bank_q   <= HIGH_RESET;
			wide_bank_q   <= '0;
		end else if (wr_en) begin
			if (wr_data[7]) begin
				shift_bits_q  <= SHIFT_RESET;
				write_count_q <= '0;
				control_q     <= control_q | 5'h0C;
			end else if (!last_bit) begin
				shift_bits_q  <= shift_next;
				write_count_q <= write_count_q + 3'd1;
			end else begin
				// fifth bit: commit to the target, then restart
				shift_bits_q  <= SHIFT_RESET;
				write_count_q <= '0;
				case (wr_addr[14:13])
					TGT_CONTROL: begin
						control_q <= shift_next;
					end
					TGT_PRG: begin
						case (control_q[3:2])
							PRG_MODE_FIX_LOW: begin
								low_bank_q  <= '0;
								high_bank_q <= shift_next[BANK_W-1:0];
							end
							PRG_MODE_FIX_HIGH: begin
								low_bank_q  <= shift_next[BANK_W-1:0];
								high_bank_q <= count_m1[BANK_W-1:0];
							end
							default: begin
								wide_bank_q <= shift_next[WIDE_W:1];
							end
						endcase
					end
					default: begin
						// character bank targets are not kept
					end
				endcase
			end
		end
	end

	assign banks.control   = control_q;
	assign banks.low_bank  = low_bank_q;
	assign banks.high_bank = high_bank_q;
	assign banks.wide_bank = wide_bank_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		write_count_q <= LAST_BIT_IDX)
		else $error("serial write count out of range");

	a_reset_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && wr_data[7] |=> control_q[3:2] == 2'b11 && write_count_q == 3'd0)
		else $error("reset write did not force program mode");

	a_empty_shift: assert property (@(posedge clk) disable iff (!arst_n)
		write_count_q == 3'd0 |-> shift_bits_q == SHIFT_RESET)
		else $error("shift register not cleared with count");

endmodule

>>> hw/rtl/sbsm_xlate.sv
module sbsm_xlate (
	input  logic [1:0]                        req_type,
	input  logic [15:0]                       addr,
	input  sbsm_pkg::bank_state_t             banks,
	output logic                              hit,
	output logic [sbsm_pkg::MAP_W-1:0]        cart_addr
);
	import sbsm_pkg::*;

	always_comb begin
		hit       = 1'b0;
		cart_addr = '0;
		case (req_type)
			REQ_CPU_RD: begin
				if (addr[15]) begin
					hit = 1'b1;
					if (banks.control[3]) begin
						// 16K mode: bit 14 splits the window
						if (!addr[14]) cart_addr = {banks.low_bank, addr[13:0]};
						else           cart_addr = {banks.high_bank, addr[13:0]};
					end else begin
						cart_addr = {banks.wide_bank, addr[14:0]};
					end
				end
			end
			REQ_CPU_WR: begin
				hit = 1'b0;
			end
			default: begin
				if (addr[15:13] == 3'd0) begin
					hit       = 1'b1;
					cart_addr = {2'b00, addr};
				end
			end
		endcase
	end

endmodule

>>> hw/rtl/serial_bank_switch_mapper.sv
// Serial bank-switch mapper, program side. Each input item is one bus access
// and yields exactly one result item (hit, cart_addr). CPU writes at or above
// 0x8000 shift data bit 0 into a five-bit serial register; the fifth write
// loads the control register (addr 14:13 = 0) or the program banks (= 3) as the
// program mode in control bits 3:2 dictates; a write with data bit 7 set clears
// the shift register and forces 16K mode with the high bank fixed. CPU reads at
// or above 0x8000 come back translated (32K or 16K windows), video accesses
// below 0x2000 pass through, everything else misses with address 0. Throughput
// is one item per clock unless out_ready holds the result register; each item
// passes the input register and then the result register, and the bank state
// is updated as an item leaves the input register so the next item already
// sees it. The result register parts the two sides: a new item is taken while
// a finished one waits for out_ready. The cfg port (prg_bank_count, 5 bits) is
// always ready and should be written only while the block is idle.
module serial_bank_switch_mapper (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [15:0]                   addr,
	input  logic [7:0]                    data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic [sbsm_pkg::MAP_W-1:0]    cart_addr,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sbsm_pkg::COUNT_W-1:0]  cfg_data
);
	import sbsm_pkg::*;

	// input stage
	logic        valid_s1;
	logic [1:0]  req_type_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	// result stage
	logic             out_valid_q;
	logic             hit_q;
	logic [MAP_W-1:0] mapped_q;

	logic             advance;
	logic             serial_wr;
	logic             hit_c;
	logic [MAP_W-1:0] mapped_c;
	bank_state_t      banks;

	// item moves from the input register into the result register
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// of the bus accesses, only CPU writes into the upper half touch the mapper state
	assign serial_wr = advance && (req_type_s1 == REQ_CPU_WR) && addr_s1[15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1 <= req_type;
			addr_s1     <= addr;
			data_s1     <= data;
		end
	end

	sbsm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (serial_wr),
		.wr_addr   (addr_s1),
		.wr_data   (data_s1),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_count (cfg_data),
		.banks     (banks)
	);

	sbsm_xlate u_xlate (
		.req_type  (req_type_s1),
		.addr      (addr_s1),
		.banks     (banks),
		.hit       (hit_c),
		.cart_addr (mapped_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q    <= hit_c;
			mapped_q <= mapped_c;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign cart_addr = mapped_q;

endmodule
